>>> hw/rtl/polygon_vertex_store_support_query_defines.svh
// ----------------------------------------------------------------------------
// polygon_vertex_store_support_query_defines
// Assertion macros for the polygon vertex store checker.
// ----------------------------------------------------------------------------
`ifndef POLYGON_VERTEX_STORE_SUPPORT_QUERY_DEFINES_SVH
`define POLYGON_VERTEX_STORE_SUPPORT_QUERY_DEFINES_SVH

// same-cycle implication
`define PVSQ_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("pvsq: same-cycle check failed");

// next-cycle implication
`define PVSQ_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("pvsq: next-cycle check failed");

`endif

>>> hw/rtl/pvsq_pkg.sv
// ----------------------------------------------------------------------------
// pvsq_pkg
// Types and codes shared by the polygon vertex store modules.
// ----------------------------------------------------------------------------
package pvsq_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int COORD_WIDTH_DEF  = 32;

   localparam logic [2:0] MODE_APPEND   = 3'd0;
   localparam logic [2:0] MODE_RECENTER = 3'd1;
   localparam logic [2:0] MODE_INSERT   = 3'd2;
   localparam logic [2:0] MODE_SUPPORT  = 3'd3;
   localparam logic [2:0] MODE_EDGE_IDX = 3'd4;
   localparam logic [2:0] MODE_EDGE_VTX = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_BAD       = 2'd3;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [4:0]         vertex_index;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] prev_x;
      logic signed [31:0] prev_y;
      logic signed [31:0] next_x;
      logic signed [31:0] next_y;
      logic [3:0]         point_index;
      logic [4:0]         vertex_total;
   } rsp_type;

endpackage

>>> hw/rtl/pvsq_ram.sv
// ----------------------------------------------------------------------------
// pvsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvsq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pvsq_div.sv
// ----------------------------------------------------------------------------
// pvsq_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pvsq_div #(
   parameter int SW   = 37,
   parameter int DIVW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [SW-1:0] dividend,
   input  logic [DIVW-1:0]      divisor,
   output logic                 done,
   output logic signed [SW-1:0] quotient
);

   localparam int STW = $clog2(SW);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [STW-1:0]  step_ff, step_in;
   logic [DIVW-1:0] rem_ff, rem_in;
   logic [DIVW-1:0] dvs_ff, dvs_in;
   logic [SW-1:0]   quo_ff, quo_in;
   logic            neg_ff, neg_in;
   logic [DIVW:0]   trial;
   logic [DIVW:0]   diff;

   assign trial = {rem_ff, quo_ff[SW-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SW-1];
         quo_in  = dividend[SW-1] ? (SW)'(-dividend) : dividend;
      end else if (run_ff) begin
         if (!diff[DIVW]) begin
            rem_in = diff[DIVW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVW-1:0];
            quo_in = {quo_ff[SW-2:0], 1'b0};
         end
         if (step_ff == STW'(SW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

>>> hw/rtl/polygon_vertex_store_support_query.sv
// ----------------------------------------------------------------------------
// polygon_vertex_store_support_query
// Polygon vertex store with append, insert, recenter, support and edge queries.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low. busy
//   stays high until the result; the result sits on rsp_item for one cycle
//   with rsp_valid high and must be taken then, there is no backpressure.
//   Vertices live in one RAM (x and y side by side, registered read data);
//   every operation that scans it walks it one address per cycle.
//   Steps from accept to rsp_valid, N = vertex count:
//     rejected or trivial commands    answered directly from idle
//     append                          shift loop over entries pos..N-1
//                                     (empty at the end), then write
//     recenter                        sum pass, divide (SW = COORD_WIDTH +
//                                     log2(MAX_VERTICES) + 1 bits), fix pass
//     insert                          append, then recenter, then read back
//     support query                   scan through read, multiply, compare stages
//     edge by index                   three reads
//     edge by vertex                  match scan, then three reads
//   One command at a time; the next may start in the cycle of the result.
//   Reset clears the vertex count; RAM contents are never read before being
//   written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_vertex_store_support_query #(
   parameter int MAX_VERTICES = pvsq_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = pvsq_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pvsq_pkg::req_type req_item,
   output logic              rsp_valid,
   output pvsq_pkg::rsp_type rsp_item
);

   import pvsq_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CNTW = $clog2(MAX_VERTICES + 1);
   localparam int SW   = CW + AW + 1;
   localparam int DW   = 2 * CW + 1;
   localparam int IW   = ((CNTW > 5) ? CNTW : 5) + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SHIFT = 4'd1;
   localparam logic [3:0] S_PUT   = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_FIX   = 4'd5;
   localparam logic [3:0] S_PICK  = 4'd6;
   localparam logic [3:0] S_SUP   = 4'd7;
   localparam logic [3:0] S_FIND  = 4'd8;
   localparam logic [3:0] S_EDGE  = 4'd9;

   function automatic logic signed [CW-1:0] f_in(input logic [31:0] v);
      logic [CW+31:0] t;
      t = {{CW{v[31]}}, v};
      return t[CW-1:0];
   endfunction

   function automatic logic [31:0] f_out(input logic [CW-1:0] v);
      logic [CW+31:0] t;
      t = {32'b0, v};
      return t[31:0];
   endfunction

   function automatic logic [3:0] f_idx(input logic [CNTW-1:0] v);
      logic [CNTW+3:0] t;
      t = {4'b0, v};
      return t[3:0];
   endfunction

   function automatic logic [4:0] f_tot(input logic [CNTW-1:0] v);
      logic [CNTW+4:0] t;
      t = {5'b0, v};
      return t[4:0];
   endfunction

   function automatic logic signed [CW-1:0] f_sat(input logic signed [CW+1:0] v);
      if ((&v[CW+1:CW-1]) || !(|v[CW+1:CW-1])) begin
         return v[CW-1:0];
      end else if (v[CW+1]) begin
         return {1'b1, {(CW-1){1'b0}}};
      end
      return {1'b0, {(CW-1){1'b1}}};
   endfunction

   logic [3:0]             state_ff, state_in;
   logic                   busy_ff, busy_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic [2:0]             mode_ff, mode_in;
   logic signed [CW-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [CNTW-1:0]        pos_ff, pos_in;
   logic                   iss_ff, iss_in;
   logic [CNTW-1:0]        ra_ff, ra_in;
   logic                   rv_ff, rv_in;
   logic [CNTW-1:0]        rq_ff, rq_in;
   logic signed [SW-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CW:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [2*CW-1:0] m1_ff, m1_in, m2_ff, m2_in;
   logic                   mv_ff, mv_in;
   logic [CNTW-1:0]        mq_ff, mq_in;
   logic signed [CW-1:0]   mx_ff, mx_in, my_ff, my_in;
   logic signed [DW-1:0]   best_ff, best_in;
   logic [CNTW-1:0]        bidx_ff, bidx_in;
   logic signed [CW-1:0]   bx_ff, bx_in, by_ff, by_in;
   logic                   found_ff, found_in;
   logic [1:0]             es_ff, es_in;
   logic [1:0]             rt_ff, rt_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_vld_ff, rsp_vld_in;

   logic                   rd_en, wr_en;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [2*CW-1:0]        wr_data, rd_data;
   logic signed [CW-1:0]   rd_x, rd_y;
   logic                   div_go, divx_done, divy_done;
   logic signed [SW-1:0]   qx, qy;
   logic [IW-1:0]          idx_w, cnt_w, pos_w;
   logic [CNTW-1:0]        rq_nx, prv, nxt, pos_nx;
   logic signed [DW-1:0]   dot;
   logic signed [CW+1:0]   fx, fy;

   assign rd_x   = rd_data[2*CW-1:CW];
   assign rd_y   = rd_data[CW-1:0];
   assign idx_w  = IW'(req_item.vertex_index);
   assign cnt_w  = IW'(cnt_ff);
   assign pos_w  = (req_item.mode == MODE_APPEND) ? cnt_w : idx_w;
   assign rq_nx  = rq_ff + 1'b1;
   assign pos_nx = pos_ff + 1'b1;
   assign prv    = (pos_ff == '0) ? cnt_ff - 1'b1 : pos_ff - 1'b1;
   assign nxt    = (pos_nx >= cnt_ff) ? '0 : pos_nx;
   assign dot    = DW'(m1_ff) + DW'(m2_ff);
   assign fx     = (CW+2)'(rd_x) - (CW+2)'(cx_ff);
   assign fy     = (CW+2)'(rd_y) - (CW+2)'(cy_ff);

   pvsq_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pvsq_div #(.SW(SW), .DIVW(CNTW)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (sx_ff),
      .divisor  (cnt_ff),
      .done     (divx_done),
      .quotient (qx)
   );

   pvsq_div #(.SW(SW), .DIVW(CNTW)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (sy_ff),
      .divisor  (cnt_ff),
      .done     (divy_done),
      .quotient (qy)
   );

   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      mode_in    = mode_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      pos_in     = pos_ff;
      iss_in     = iss_ff;
      ra_in      = ra_ff;
      rv_in      = 1'b0;
      rq_in      = rq_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      m1_in      = m1_ff;
      m2_in      = m2_ff;
      mv_in      = 1'b0;
      mq_in      = mq_ff;
      mx_in      = mx_ff;
      my_in      = my_ff;
      best_in    = best_ff;
      bidx_in    = bidx_ff;
      bx_in      = bx_ff;
      by_in      = by_ff;
      found_in   = found_ff;
      es_in      = es_ff;
      rt_in      = rt_ff;
      rsp_in     = rsp_ff;
      rsp_vld_in = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      div_go     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in              = '0;
               rsp_in.status       = ST_OK;
               rsp_in.vertex_total = f_tot(cnt_ff);
               mode_in = req_item.mode;
               px_in   = f_in(req_item.pos_x);
               py_in   = f_in(req_item.pos_y);
               dx_in   = f_in(req_item.dir_x);
               dy_in   = f_in(req_item.dir_y);
               iss_in  = 1'b1;
               ra_in   = '0;
               sx_in   = '0;
               sy_in   = '0;
               best_in = '0;
               bidx_in = '0;
               found_in = 1'b0;
               es_in   = '0;
               busy_in = 1'b1;
               unique case (req_item.mode)
                  MODE_APPEND, MODE_INSERT: begin
                     if (cnt_ff >= CNTW'(MAX_VERTICES)) begin
                        rsp_in.status = ST_FULL;
                     end else if (pos_w > cnt_w) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        pos_in   = pos_w[CNTW-1:0];
                        iss_in   = cnt_w > pos_w;
                        ra_in    = cnt_ff - 1'b1;
                        state_in = S_SHIFT;
                     end
                  end
                  MODE_RECENTER: begin
                     if (cnt_ff != '0) begin
                        state_in = S_SUM;
                     end
                  end
                  MODE_SUPPORT: begin
                     if (cnt_ff == '0) rsp_in.status = ST_BAD;
                     else state_in = S_SUP;
                  end
                  MODE_EDGE_IDX: begin
                     if (cnt_ff == '0 || idx_w >= cnt_w) begin
                        rsp_in.status = ST_BAD;
                     end else begin
                        pos_in   = idx_w[CNTW-1:0];
                        state_in = S_EDGE;
                     end
                  end
                  MODE_EDGE_VTX: begin
                     if (cnt_ff == '0) rsp_in.status = ST_BAD;
                     else state_in = S_FIND;
                  end
                  default: rsp_in.status = ST_BAD;
               endcase
               if (state_in == S_IDLE) begin
                  busy_in    = 1'b0;
                  rsp_vld_in = 1'b1;
               end
            end
         end
         S_SHIFT: begin
            // move entries pos..count-1 up by one, highest first
            if (iss_ff) begin
               rd_en   = 1'b1;
               rd_addr = ra_ff[AW-1:0];
               rv_in   = 1'b1;
               rq_in   = ra_ff;
               if (ra_ff == pos_ff) iss_in = 1'b0;
               else ra_in = ra_ff - 1'b1;
            end
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = rq_nx[AW-1:0];
               wr_data = rd_data;
            end
            if (!iss_ff && !rv_ff) state_in = S_PUT;
         end
         S_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = {px_ff, py_ff};
            cnt_in  = cnt_ff + 1'b1;
            rsp_in.vertex_total = f_tot(cnt_ff + 1'b1);
            rsp_in.point_index  = f_idx(pos_ff);
            if (mode_ff == MODE_INSERT) begin
               iss_in   = 1'b1;
               ra_in    = '0;
               state_in = S_SUM;
            end else begin
               rsp_in.point_x = f_out(px_ff);
               rsp_in.point_y = f_out(py_ff);
               busy_in    = 1'b0;
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SUM: begin
            if (iss_ff) begin
               rd_en   = 1'b1;
               rd_addr = ra_ff[AW-1:0];
               rv_in   = 1'b1;
               rq_in   = ra_ff;
               if (ra_ff == cnt_ff - 1'b1) iss_in = 1'b0;
               else ra_in = ra_ff + 1'b1;
            end
            if (rv_ff) begin
               sx_in = sx_ff + SW'(rd_x);
               sy_in = sy_ff + SW'(rd_y);
            end
            if (!iss_ff && !rv_ff) begin
               div_go   = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (divx_done && divy_done) begin
               cx_in    = qx[CW:0];
               cy_in    = qy[CW:0];
               iss_in   = 1'b1;
               ra_in    = '0;
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            // read one vertex, write it back shifted the next cycle
            if (iss_ff) begin
               rd_en   = 1'b1;
               rd_addr = ra_ff[AW-1:0];
               rv_in   = 1'b1;
               rq_in   = ra_ff;
               if (ra_ff == cnt_ff - 1'b1) iss_in = 1'b0;
               else ra_in = ra_ff + 1'b1;
            end
            if (rv_ff) begin
               wr_en   = 1'b1;
               wr_addr = rq_ff[AW-1:0];
               wr_data = {f_sat(fx), f_sat(fy)};
            end
            if (!iss_ff && !rv_ff) begin
               if (mode_ff == MODE_INSERT) begin
                  rd_en    = 1'b1;
                  rd_addr  = pos_ff[AW-1:0];
                  state_in = S_PICK;
               end else begin
                  busy_in    = 1'b0;
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_PICK: begin
            rsp_in.point_x = f_out(rd_x);
            rsp_in.point_y = f_out(rd_y);
            busy_in    = 1'b0;
            rsp_vld_in = 1'b1;
            state_in   = S_IDLE;
         end
         S_SUP: begin
            if (iss_ff) begin
               rd_en   = 1'b1;
               rd_addr = ra_ff[AW-1:0];
               rv_in   = 1'b1;
               rq_in   = ra_ff;
               if (ra_ff == cnt_ff - 1'b1) iss_in = 1'b0;
               else ra_in = ra_ff + 1'b1;
            end
            if (rv_ff) begin
               m1_in = dx_ff * rd_x;
               m2_in = dy_ff * rd_y;
               mv_in = 1'b1;
               mq_in = rq_ff;
               mx_in = rd_x;
               my_in = rd_y;
            end
            if (mv_ff) begin
               // vertex 0 is the fallback when nothing scores positive
               if (mq_ff == '0) begin
                  bx_in = mx_ff;
                  by_in = my_ff;
               end
               if (dot > best_ff) begin
                  best_in = dot;
                  bidx_in = mq_ff;
                  bx_in   = mx_ff;
                  by_in   = my_ff;
               end
            end
            if (!iss_ff && !rv_ff && !mv_ff) begin
               rsp_in.point_x     = f_out(bx_ff);
               rsp_in.point_y     = f_out(by_ff);
               rsp_in.point_index = f_idx(bidx_ff);
               busy_in    = 1'b0;
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_FIND: begin
            if (iss_ff) begin
               rd_en   = 1'b1;
               rd_addr = ra_ff[AW-1:0];
               rv_in   = 1'b1;
               rq_in   = ra_ff;
               if (ra_ff == cnt_ff - 1'b1) iss_in = 1'b0;
               else ra_in = ra_ff + 1'b1;
            end
            if (rv_ff && !found_ff && rd_x == px_ff && rd_y == py_ff) begin
               found_in = 1'b1;
               pos_in   = rq_ff;
            end
            if (!iss_ff && !rv_ff) begin
               if (found_ff) begin
                  state_in = S_EDGE;
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
                  busy_in    = 1'b0;
                  rsp_vld_in = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_EDGE: begin
            // reads tagged 0 prev, 1 current, 2 next
            if (es_ff != 2'd3) begin
               rd_en = 1'b1;
               unique case (es_ff)
                  2'd0:    rd_addr = prv[AW-1:0];
                  2'd1:    rd_addr = pos_ff[AW-1:0];
                  default: rd_addr = nxt[AW-1:0];
               endcase
               rv_in = 1'b1;
               rt_in = es_ff;
               es_in = es_ff + 1'b1;
            end
            if (rv_ff) begin
               unique case (rt_ff)
                  2'd0: begin
                     rsp_in.prev_x = f_out(rd_x);
                     rsp_in.prev_y = f_out(rd_y);
                  end
                  2'd1: begin
                     rsp_in.point_x     = f_out(rd_x);
                     rsp_in.point_y     = f_out(rd_y);
                     rsp_in.point_index = f_idx(pos_ff);
                  end
                  default: begin
                     rsp_in.next_x = f_out(rd_x);
                     rsp_in.next_y = f_out(rd_y);
                     busy_in    = 1'b0;
                     rsp_vld_in = 1'b1;
                     state_in   = S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         busy_ff    <= 1'b0;
         cnt_ff     <= '0;
         iss_ff     <= 1'b0;
         rv_ff      <= 1'b0;
         mv_ff      <= 1'b0;
         found_ff   <= 1'b0;
         es_ff      <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         busy_ff    <= busy_in;
         cnt_ff     <= cnt_in;
         iss_ff     <= iss_in;
         rv_ff      <= rv_in;
         mv_ff      <= mv_in;
         found_ff   <= found_in;
         es_ff      <= es_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      mode_ff <= mode_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      pos_ff  <= pos_in;
      ra_ff   <= ra_in;
      rq_ff   <= rq_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      m1_ff   <= m1_in;
      m2_ff   <= m2_in;
      mq_ff   <= mq_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      best_ff <= best_in;
      bidx_ff <= bidx_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      rt_ff   <= rt_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

endmodule

>>> hw/rtl/pvsq_checker.sv
// ----------------------------------------------------------------------------
// pvsq_checker
// Port-level checks on the polygon vertex store command transactions.
// ----------------------------------------------------------------------------
`include "polygon_vertex_store_support_query_defines.svh"

module pvsq_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input pvsq_pkg::rsp_type rsp_item
);

   import pvsq_pkg::*;

   // an accepted command either finishes at once or holds busy
   `PVSQ_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy || rsp_valid)
   // busy only drops together with a result
   `PVSQ_ASSERT_NXT(a_busy_ends, clock, reset, busy, busy || rsp_valid)
   `PVSQ_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, !busy)
   // failed commands report no vertex
   `PVSQ_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_item.status != ST_OK,
                    rsp_item.point_index == 4'd0 && rsp_item.point_x == 32'sd0)

endmodule

bind polygon_vertex_store_support_query pvsq_checker u_pvsq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
